/* sv/dlr_pkg.sv */
`timescale 1ns / 1ps

package dlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	// accumulator: integer part, fraction, one guard bit
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
	// increment magnitude is at most 1.0, plus sign
	localparam int INC_W = FRAC_BITS + 2;
	localparam int QUO_W = FRAC_BITS + 1;
	// dividend |d| * 2^(F+1) + len, one carry bit
	localparam int NUM_W = COORD_BITS + FRAC_BITS + 2;
	// divisor 2 * len
	localparam int DEN_W = COORD_BITS + 1;
	localparam int REM_W = COORD_BITS + 2;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic {
		BK_READY,
		BK_DIV
	} back_state_t;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic                  neg_x;
		logic                  neg_y;
		logic [COORD_BITS-1:0] mag_x;
		logic [COORD_BITS-1:0] mag_y;
		logic [COORD_BITS-1:0] len;
	} cmd_t;

	// round half away from zero: (acc + half - sign) >>> FRAC_BITS
	function automatic logic [COORD_BITS-1:0] round_point(input logic [ACC_W-1:0] acc);
		logic [ACC_W:0] ext;
		logic [ACC_W:0] bias;
		logic [ACC_W:0] sum;
		ext  = {acc[ACC_W-1], acc};
		bias = {{(ACC_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}}
			- {{ACC_W{1'b0}}, acc[ACC_W-1]};
		sum  = ext + bias;
		return sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
	endfunction

endpackage

/* sv/dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// With the back end free, an accepted input reaches the earliest output acceptance through
//   the queue write, then the output register.
// Step transactions: one point per cycle while unstalled, paced by the accumulator adders.
// Start transactions: the first endpoint comes out at once; unless the line has zero length,
//   the restoring divider then runs before the back end pops the next command; meanwhile
//   the queue keeps taking input until QUEUE_DEPTH (4) commands wait.
// Reset (arst_n low, async): queue empty, back end idle, no line in progress, no output.

module dda_line_rasterizer import dlr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         operation,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         pixel_valid,
	input  logic                         pixel_stall,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         last
);

	// front end -> queue
	logic push;
	cmd_t push_cmd;
	logic full;

	// queue -> back end
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// Front end: takes the input transaction, works out deltas, their
	// magnitudes and the line length, and writes one command to the queue.
	dlr_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.full       (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Short command queue; lets the input keep flowing while the
	// divider or a stalled output holds the back end.
	dlr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Back end: holds line state, runs the increment division, steps the
	// accumulators and owns the output register. Steps with no line in
	// progress are dropped here without a result.
	dlr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last        (last)
	);

endmodule

/* sv/dlr_front.sv */
`timescale 1ns / 1ps

module dlr_front import dlr_pkg::*; (
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         operation,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic                         full,
	output logic                         push,
	output cmd_t                         push_cmd
);

	logic [COORD_BITS:0]   dx;
	logic [COORD_BITS:0]   dy;
	logic [COORD_BITS:0]   abs_x;
	logic [COORD_BITS:0]   abs_y;
	logic [COORD_BITS-1:0] mag_x;
	logic [COORD_BITS-1:0] mag_y;

	assign item_stall = full;
	assign push       = item_valid && !full;

	always_comb begin
		dx    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
		dy    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		abs_x = dx[COORD_BITS] ? -dx : dx;
		abs_y = dy[COORD_BITS] ? -dy : dy;
		mag_x = abs_x[COORD_BITS-1:0];
		mag_y = abs_y[COORD_BITS-1:0];

		push_cmd.op    = op_t'(operation);
		push_cmd.sx    = start_x;
		push_cmd.sy    = start_y;
		push_cmd.neg_x = dx[COORD_BITS];
		push_cmd.neg_y = dy[COORD_BITS];
		push_cmd.mag_x = mag_x;
		push_cmd.mag_y = mag_y;
		push_cmd.len   = (mag_x >= mag_y) ? mag_x : mag_y;
	end

endmodule

/* sv/dlr_queue.sv */
`timescale 1ns / 1ps

module dlr_queue import dlr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

/* sv/dlr_back.sv */
`timescale 1ns / 1ps

module dlr_back import dlr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  cmd_t                         head_cmd,
	output logic                         pop,
	output logic                         pixel_valid,
	input  logic                         pixel_stall,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         last
);

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_lane_t;

	// one restoring step; quotient bits shift in behind the dividend
	function automatic div_lane_t div_step(input logic [REM_W-1:0] rem,
			input logic [NUM_W-1:0] num, input logic [DEN_W-1:0] den);
		logic [REM_W-1:0] sh;
		logic             ge;
		div_lane_t        r;
		sh      = {rem[REM_W-2:0], num[NUM_W-1]};
		ge      = (sh >= {1'b0, den});
		r.rem   = ge ? sh - {1'b0, den} : sh;
		r.num   = {num[NUM_W-2:0], ge};
		return r;
	endfunction

	function automatic logic [INC_W-1:0] signed_inc(input logic neg,
			input logic [QUO_W-1:0] q);
		return neg ? -{1'b0, q} : {1'b0, q};
	endfunction

	back_state_t state_q, state_d;

	logic                  busy_q;
	logic [COORD_BITS-1:0] steps_q;
	logic [ACC_W-1:0]      acc_x_q, acc_y_q;
	logic [INC_W-1:0]      inc_x_q, inc_y_q;
	logic [REM_W-1:0]      rem_x_q, rem_y_q;
	logic [NUM_W-1:0]      num_x_q, num_y_q;
	logic [DEN_W-1:0]      den_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  neg_x_q, neg_y_q;

	logic                  out_valid_q;
	logic [ACC_W-1:0]      out_x_q, out_y_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  start_go;
	logic                  step_go;
	logic                  len_zero;
	logic                  div_done;
	logic                  final_step;
	logic [ACC_W-1:0]      start_acc_x, start_acc_y;
	logic [ACC_W-1:0]      step_acc_x, step_acc_y;
	logic [NUM_W-1:0]      load_num_x, load_num_y;
	div_lane_t             lane_x_d, lane_y_d;

	assign out_free   = !out_valid_q || !pixel_stall;
	assign len_zero   = (head_cmd.len == '0);
	assign div_done   = (cnt_q == '0);
	assign final_step = (steps_q == COORD_BITS'(1));

	assign start_acc_x = {{(ACC_W - COORD_BITS - FRAC_BITS){head_cmd.sx[COORD_BITS-1]}},
		head_cmd.sx, {FRAC_BITS{1'b0}}};
	assign start_acc_y = {{(ACC_W - COORD_BITS - FRAC_BITS){head_cmd.sy[COORD_BITS-1]}},
		head_cmd.sy, {FRAC_BITS{1'b0}}};
	assign step_acc_x  = acc_x_q + {{(ACC_W - INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
	assign step_acc_y  = acc_y_q + {{(ACC_W - INC_W){inc_y_q[INC_W-1]}}, inc_y_q};

	assign load_num_x = {1'b0, head_cmd.mag_x, {QUO_W{1'b0}}}
		+ {{(NUM_W - COORD_BITS){1'b0}}, head_cmd.len};
	assign load_num_y = {1'b0, head_cmd.mag_y, {QUO_W{1'b0}}}
		+ {{(NUM_W - COORD_BITS){1'b0}}, head_cmd.len};

	assign lane_x_d = div_step(rem_x_q, num_x_q, den_q);
	assign lane_y_d = div_step(rem_y_q, num_y_q, den_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_READY: if (start_go && !len_zero) state_d = BK_DIV;
			BK_DIV:   if (div_done) state_d = BK_READY;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = 1'b0;
		start_go = 1'b0;
		step_go  = 1'b0;
		unique case (state_q)
			BK_READY: begin
				if (head_valid) begin
					unique case (head_cmd.op)
						OP_START: begin
							pop      = out_free;
							start_go = out_free;
						end
						OP_STEP: begin
							if (!busy_q) begin
								pop = 1'b1;
							end else begin
								pop     = out_free;
								step_go = out_free;
							end
						end
					endcase
				end
			end
			BK_DIV: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_READY;
			busy_q      <= 1'b0;
			steps_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_go) begin
				busy_q  <= !len_zero;
				steps_q <= head_cmd.len;
				cnt_q   <= DIV_CNT_W'(NUM_W - 1);
			end else if (step_go) begin
				busy_q  <= !final_step;
				steps_q <= steps_q - 1'b1;
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (start_go || step_go)
				out_valid_q <= 1'b1;
			else if (!pixel_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_go) begin
			acc_x_q    <= start_acc_x;
			acc_y_q    <= start_acc_y;
			out_x_q    <= start_acc_x;
			out_y_q    <= start_acc_y;
			out_last_q <= len_zero;
			inc_x_q    <= '0;
			inc_y_q    <= '0;
			rem_x_q    <= '0;
			rem_y_q    <= '0;
			num_x_q    <= load_num_x;
			num_y_q    <= load_num_y;
			den_q      <= {head_cmd.len, 1'b0};
			neg_x_q    <= head_cmd.neg_x;
			neg_y_q    <= head_cmd.neg_y;
		end else if (step_go) begin
			acc_x_q    <= step_acc_x;
			acc_y_q    <= step_acc_y;
			out_x_q    <= step_acc_x;
			out_y_q    <= step_acc_y;
			out_last_q <= final_step;
		end else if (state_q == BK_DIV) begin
			rem_x_q <= lane_x_d.rem;
			rem_y_q <= lane_y_d.rem;
			num_x_q <= lane_x_d.num;
			num_y_q <= lane_y_d.num;
			if (div_done) begin
				inc_x_q <= signed_inc(neg_x_q, lane_x_d.num[QUO_W-1:0]);
				inc_y_q <= signed_inc(neg_y_q, lane_y_d.num[QUO_W-1:0]);
			end
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_x     = round_point(out_x_q);
	assign pixel_y     = round_point(out_y_q);
	assign last        = out_last_q;

endmodule
